[rtl/wlg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlg_pkg
// Shared types, constants and the gray ramp division step for the
// window/level grayscale table.
// ----------------------------------------------------------------------------
package wlg_pkg;

	// Upper clamp on the number of table entries in use.
	localparam int unsigned MAX_COLORS = 4096;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_WINDOW_WIDTH  = 3'd0,
		REG_LEVEL_CENTER  = 3'd1,
		REG_RANGE_LOW     = 3'd2,
		REG_RANGE_HIGH    = 3'd3,
		REG_INVERSE_VIDEO = 3'd4,
		REG_BELOW_COLOR   = 3'd5,
		REG_ABOVE_COLOR   = 3'd6,
		REG_COLOR_COUNT   = 3'd7
	} reg_idx_t;

	// States of the ramp end index divider.
	typedef enum logic [1:0] {
		DV_IDLE,
		DV_MUL,
		DV_RUN
	} div_state_t;

	// Payload that travels down the lookup pipeline.
	typedef struct packed {
		logic        ramp;   // entry lies inside the gray ramp
		logic [31:0] color;  // fixed color for entries outside the ramp
		logic [20:0] rem;    // running remainder of the gray division
		logic [12:0] dvs;    // divisor, twice the ramp length
		logic [7:0]  quo;    // gray level built so far
	} ramp_t;

	// Two restoring division steps, quotient bits hi and hi-1.
	function automatic ramp_t div2(ramp_t x, int unsigned hi);
		ramp_t       y;
		logic [20:0] sh;
		y = x;
		for (int i = 0; i < 2; i++) begin
			sh = 21'(y.dvs) << (hi - i);
			if (y.rem >= sh) begin
				y.rem = y.rem - sh;
				y.quo[3'(hi - i)] = 1'b1;
			end
		end
		return y;
	endfunction

endpackage

[rtl/wlg_idx_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlg_idx_div
// Maps one ramp end to a table index: trunc(num * n / span2), clamped to
// 0..n-1, by one multiply and a bit-serial restoring division.
// ----------------------------------------------------------------------------
module wlg_idx_div import wlg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [35:0] num,
	input  logic signed [33:0] span2,
	input  logic        [12:0] n,
	output logic               busy,
	output logic        [11:0] idx
);

	div_state_t  state_q, state_d;
	logic [35:0] mag_q;
	logic [33:0] div_q;
	logic        zero_q;
	logic [12:0] n_q;
	logic [48:0] rem_q;
	logic [13:0] quo_q;
	logic [3:0]  cnt_q;
	logic [48:0] shifted;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; a new start always restarts the unit.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: state_d = DV_IDLE;
			DV_MUL:  state_d = DV_RUN;
			DV_RUN:  state_d = (cnt_q == 4'd0) ? DV_IDLE : DV_RUN;
			default: state_d = DV_IDLE;
		endcase
		if (start) begin
			state_d = DV_MUL;
		end
	end

	assign busy    = (state_q != DV_IDLE);
	assign shifted = 49'(div_q) << cnt_q;

	// Operand capture, product and one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= num[35] ? 36'(-num) : 36'(num);
			div_q  <= span2[33] ? 34'(-span2) : 34'(span2);
			zero_q <= (num == '0) || (span2 == '0) || (num[35] != span2[33]);
			n_q    <= n;
			quo_q  <= '0;
			cnt_q  <= 4'd13;
		end else if (state_q == DV_MUL) begin
			rem_q <= 49'(mag_q) * 49'(n_q);
		end else if (state_q == DV_RUN) begin
			if (rem_q >= shifted) begin
				rem_q        <= rem_q - shifted;
				quo_q[cnt_q] <= 1'b1;
			end
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// A negative or empty mapping clamps to zero, a large one to n-1.
	always_comb begin
		if (zero_q) begin
			idx = '0;
		end else if (quo_q >= 14'(n_q)) begin
			idx = 12'(n_q - 13'd1);
		end else begin
			idx = 12'(quo_q);
		end
	end

endmodule

[rtl/window_level_gray_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_level_gray_table
// Window/level grayscale lookup table: one RGBA entry per table index.
// ----------------------------------------------------------------------------
// Usage:
//  The s_axis channel carries an entry index, the m_axis channel returns
//  the RGBA color of that entry, one result transaction per input
//  transaction and in the same order. The cfg channel writes the eight
//  registers (window, level, range, inverse video, colors, count); it is
//  always ready.
//  The pipeline takes one transaction per clock unless the receiver stalls
//  or the index dividers run. The gray level is a restoring division done
//  two bits per stage over four stages.
//  The ramp start and end indexes are worked out from the registers by two
//  serial dividers, one quotient bit per cycle. After reset and after every
//  register write, s_axis_tready stays low while they run.
//  When the receiver stalls, the output register holds and the whole
//  pipeline freezes, so s_axis_tready drops; nothing is lost or repeated.
//  Reset loads the documented register defaults and empties the pipeline.
// ----------------------------------------------------------------------------
module window_level_gray_table import wlg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] entry_index, [15:12] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // red, green, blue, alpha, 8 bits each
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] window_width_q, level_center_q, range_low_q, range_high_q;
	logic               inverse_video_q;
	logic [31:0]        below_color_q, above_color_q;
	logic [12:0]        color_count_q;
	logic               pending_q;

	logic [12:0]        n;
	logic signed [35:0] num_start, num_end, lev2, win, lo2;
	logic signed [33:0] span2;
	logic               busy_a, busy_b, busy;
	logic [11:0]        q_start, q_end, start_idx, end_idx;

	logic               en, accept;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	ramp_t              st_s1, st_s2, st_s3, st_s4, st_s5, st_in;
	logic [11:0]        e, k, d;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_width_q  <= 32'sd16777216;
			level_center_q  <= 32'sd8388608;
			range_low_q     <= 32'sd0;
			range_high_q    <= 32'sd65536;
			inverse_video_q <= 1'b0;
			below_color_q   <= 32'h0000_00FF;
			above_color_q   <= 32'hFFFF_FFFF;
			color_count_q   <= 13'd256;
			pending_q       <= 1'b1;
		end else begin
			pending_q <= cfg_valid;
			if (cfg_valid) begin
				unique case (reg_idx_t'(cfg_index))
					REG_WINDOW_WIDTH:  window_width_q  <= cfg_data;
					REG_LEVEL_CENTER:  level_center_q  <= cfg_data;
					REG_RANGE_LOW:     range_low_q     <= cfg_data;
					REG_RANGE_HIGH:    range_high_q    <= cfg_data;
					REG_INVERSE_VIDEO: inverse_video_q <= cfg_data[0];
					REG_BELOW_COLOR:   below_color_q   <= cfg_data;
					REG_ABOVE_COLOR:   above_color_q   <= cfg_data;
					REG_COLOR_COUNT:   color_count_q   <= cfg_data[12:0];
					default: ;
				endcase
			end
		end
	end

	// Effective count and the doubled scalar offsets of both ramp ends.
	always_comb begin
		if (color_count_q < 13'd2) begin
			n = 13'd2;
		end else if (color_count_q > 13'(MAX_COLORS)) begin
			n = 13'(MAX_COLORS);
		end else begin
			n = color_count_q;
		end
		lev2      = 36'(level_center_q) <<< 1;
		win       = 36'(window_width_q);
		lo2       = 36'(range_low_q) <<< 1;
		num_start = lev2 - win - lo2;
		num_end   = lev2 + win - lo2;
		span2     = (34'(range_high_q) - 34'(range_low_q)) <<< 1;
	end

	wlg_idx_div u_div_start (
		.clk   (clk),
		.arst_n(arst_n),
		.start (pending_q),
		.num   (num_start),
		.span2 (span2),
		.n     (n),
		.busy  (busy_a),
		.idx   (q_start)
	);

	wlg_idx_div u_div_end (
		.clk   (clk),
		.arst_n(arst_n),
		.start (pending_q),
		.num   (num_end),
		.span2 (span2),
		.n     (n),
		.busy  (busy_b),
		.idx   (q_end)
	);

	assign busy      = pending_q | busy_a | busy_b;
	assign start_idx = (q_start == '0) ? 12'd1 : q_start;
	assign end_idx   = (q_end == '0) ? 12'd1 : q_end;

	// Handshake: the pipeline moves whenever the output register is free.
	assign en            = !v_s5 || m_axis_tready;
	assign s_axis_tready = en && !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Stage 1 setup: classify the entry and form the gray dividend.
	always_comb begin
		e           = s_axis_tdata[11:0];
		k           = e - start_idx;
		d           = end_idx - start_idx;
		st_in       = '0;
		st_in.ramp  = (e < end_idx) && (e >= start_idx);
		if (e >= end_idx) begin
			st_in.color = inverse_video_q ? below_color_q : above_color_q;
		end else begin
			st_in.color = inverse_video_q ? above_color_q : below_color_q;
		end
		if (inverse_video_q) begin
			st_in.rem = 21'd511 * 21'(d) - 21'd510 * 21'(k);
		end else begin
			st_in.rem = 21'd510 * 21'(k) + 21'(d);
		end
		st_in.dvs = {d, 1'b0};
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Payload stages: two quotient bits per stage.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_in;
			st_s2 <= div2(st_s1, 7);
			st_s3 <= div2(st_s2, 5);
			st_s4 <= div2(st_s3, 3);
			st_s5 <= div2(st_s4, 1);
		end
	end

	// Output: red in the lowest byte.
	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = st_s5.ramp ?
		{8'hFF, st_s5.quo, st_s5.quo, st_s5.quo} :
		{st_s5.color[7:0], st_s5.color[15:8], st_s5.color[23:16], st_s5.color[31:24]};

	// Once the dividers settle, both ramp ends lie inside the table.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (start_idx >= 12'd1) && (13'(start_idx) < n) && (end_idx >= 12'd1))
		else $error("ramp index out of range");

	// A ramp entry always divides out within eight quotient bits.
	a_gray_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && st_s5.ramp) |-> (st_s5.rem < 21'(st_s5.dvs)))
		else $error("gray division left a remainder too large");

	// A write restarts the index dividers and blocks new input.
	a_cfg_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> !s_axis_tready ##1 (busy_a && busy_b))
		else $error("index recompute not started after a register write");

endmodule

[test/wlg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlg_checker
// Watches the configuration, index and color channels of the window/level
// gray table, predicts each color and compares it with the returned one.
// ----------------------------------------------------------------------------
module wlg_checker import wlg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_colors
);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// Shadow copy of the registers.
	logic signed [31:0] win_r, lev_r, rlo_r, rhi_r;
	logic               inv_r;
	logic [31:0]        below_r, above_r;
	logic [12:0]        count_r;

	rgba_t color_queue[$];

	assign pending_colors = color_queue.size();

	// Maps a doubled scalar to a clamped table index.
	function automatic longint ramp_index(longint twice_s, longint n);
		longint span2, q;
		span2 = 2 * (longint'(rhi_r) - longint'(rlo_r));
		if (span2 == 0)
			q = 0;
		else
			q = ((twice_s - 2 * longint'(rlo_r)) * n) / span2;
		if (q < 0)
			q = 0;
		if (q >= n)
			q = n - 1;
		return q;
	endfunction

	function automatic rgba_t entry_color(logic [11:0] entry);
		longint n, lev2, st, en, e, k, d, g;
		rgba_t  c;
		n = count_r;
		if (n < 2)
			n = 2;
		if (n > MAX_COLORS)
			n = MAX_COLORS;
		lev2 = 2 * longint'(lev_r);
		st = ramp_index(lev2 - longint'(win_r), n);
		en = ramp_index(lev2 + longint'(win_r), n);
		if (st < 1)
			st = 1;
		if (en < 1)
			en = 1;
		e = entry;
		if (e >= en) begin
			c = inv_r ? below_r : above_r;
		end else if (e < st) begin
			c = inv_r ? above_r : below_r;
		end else begin
			k = e - st;
			d = en - st;
			if (inv_r)
				g = (511 * d - 510 * k) / (2 * d);
			else
				g = (510 * k + d) / (2 * d);
			if (g < 0)
				g = 0;
			if (g > 255)
				g = 255;
			c = {8'(g), 8'(g), 8'(g), 8'd255};
		end
		return c;
	endfunction

	// Register writes, predictions and comparisons.
	always @(posedge clk or negedge arst_n) begin
		rgba_t want, got;
		if (!arst_n) begin
			win_r <= 32'sd16777216;
			lev_r <= 32'sd8388608;
			rlo_r <= '0;
			rhi_r <= 32'sd65536;
			inv_r <= 1'b0;
			below_r <= 32'h0000_00FF;
			above_r <= 32'hFFFF_FFFF;
			count_r <= 13'd256;
			fail_count <= 0;
			color_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_WINDOW_WIDTH:  win_r <= cfg_data;
					REG_LEVEL_CENTER:  lev_r <= cfg_data;
					REG_RANGE_LOW:     rlo_r <= cfg_data;
					REG_RANGE_HIGH:    rhi_r <= cfg_data;
					REG_INVERSE_VIDEO: inv_r <= cfg_data[0];
					REG_BELOW_COLOR:   below_r <= cfg_data;
					REG_ABOVE_COLOR:   above_r <= cfg_data;
					REG_COLOR_COUNT:   count_r <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				color_queue.push_back(entry_color(s_axis_tdata[11:0]));
			if (m_axis_tvalid && m_axis_tready) begin
				// Red arrives in the lowest byte of the color transaction.
				got = {m_axis_tdata[7:0], m_axis_tdata[15:8],
					m_axis_tdata[23:16], m_axis_tdata[31:24]};
				if (color_queue.size() == 0) begin
					$error("unexpected color transaction %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = color_queue.pop_front();
					if (want.red !== got.red)
						$error("red: expected %0d, got %0d", want.red, got.red);
					if (want.green !== got.green)
						$error("green: expected %0d, got %0d", want.green, got.green);
					if (want.blue !== got.blue)
						$error("blue: expected %0d, got %0d", want.blue, got.blue);
					if (want.alpha !== got.alpha)
						$error("alpha: expected %0d, got %0d", want.alpha, got.alpha);
					if (want !== got)
						fail_count <= fail_count + 1;
				end
			end
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives index transactions through the window/level gray table under
// several register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench import wlg_pkg::*;;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          pending_colors;
	int          idle_cycles = 0;
	bit          long_hold = 1'b0;
	bit          hold_done = 1'b0;

	localparam int WATCHDOG_LIMIT = 5000;

	always #6 clk = ~clk;

	window_level_gray_table u_dut (.*);

	wlg_checker u_checker (.*);

	// Receiver stall pattern, with one long hold-off on request.
	always @(posedge clk) begin
		int hold;
		if (long_hold && !hold_done) begin
			m_axis_tready <= 1'b0;
			for (hold = 0; hold < 60; hold++)
				@(posedge clk);
			hold_done <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sends one index transaction; the burst gap is handled by the caller.
	task automatic send_entry(logic [11:0] entry);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, entry};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_burst_of(int n, int maxval);
		int i, gap;
		for (i = 0; i < n; i++) begin
			send_entry(12'($urandom_range(0, maxval)));
			if ($urandom_range(0, 5) == 0) begin
				s_axis_tvalid <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain;
		@(posedge clk);
		while (pending_colors != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_setting;
		int sel;
		logic [31:0] lo, span;
		sel = $urandom_range(0, 3);
		lo = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 65536)) - 32'd32768;
		span = sel == 0 ? $urandom() : 32'($urandom_range(1, 1 << 20));
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, lo + span);
		write_reg(REG_LEVEL_CENTER, lo + 32'($urandom_range(0, 1 << 20)) - 32'h40000);
		write_reg(REG_WINDOW_WIDTH, sel == 1 ? $urandom() : 32'($urandom_range(0, 1 << 20)));
		write_reg(REG_INVERSE_VIDEO, $urandom());
		write_reg(REG_BELOW_COLOR, $urandom());
		write_reg(REG_ABOVE_COLOR, $urandom());
		write_reg(REG_COLOR_COUNT, sel == 2 ? $urandom() : 32'($urandom_range(0, 300)));
	endtask

	initial begin
		int phase, i;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed entries under the reset settings, extremes included.
		send_entry(12'd0);
		send_entry(12'd1);
		send_entry(12'd127);
		send_entry(12'd128);
		send_entry(12'd255);
		send_entry(12'd256);
		send_entry(12'hFFF);
		s_axis_tvalid <= 1'b0;
		drain();

		// Inverse video, full count and the empty range.
		write_reg(REG_INVERSE_VIDEO, 32'd1);
		write_reg(REG_COLOR_COUNT, 32'd4096);
		write_reg(REG_WINDOW_WIDTH, 32'h8000_0000);
		write_reg(REG_LEVEL_CENTER, 32'h7FFF_FFFF);
		send_entry(12'd0);
		send_entry(12'd2048);
		send_entry(12'hFFF);
		s_axis_tvalid <= 1'b0;
		drain();
		write_reg(REG_RANGE_HIGH, 32'd0);
		write_reg(REG_COLOR_COUNT, 32'h1FFF);
		send_entry(12'd0);
		send_entry(12'd1);
		send_entry(12'hFFF);
		s_axis_tvalid <= 1'b0;
		drain();

		// Count below two, end before start, negative span.
		write_reg(REG_COLOR_COUNT, 32'd0);
		write_reg(REG_RANGE_LOW, 32'h0001_0000);
		write_reg(REG_RANGE_HIGH, 32'h0000_0000);
		write_reg(REG_WINDOW_WIDTH, 32'hFFFF_0000);
		write_reg(REG_LEVEL_CENTER, 32'h8000_0000);
		write_reg(REG_BELOW_COLOR, 32'h0000_0000);
		write_reg(REG_ABOVE_COLOR, 32'hA5A5_5A5A);
		send_entry(12'd0);
		send_entry(12'd1);
		send_entry(12'd2);
		s_axis_tvalid <= 1'b0;
		drain();

		// Random phases; the first one holds the receiver off for a while.
		for (phase = 0; phase < 12; phase++) begin
			random_setting();
			if (phase == 0)
				long_hold <= 1'b1;
			for (i = 0; i < 11; i++)
				send_burst_of($urandom_range(1, 16), $urandom_range(0, 7) == 0 ? 4095 : 320);
			drain();
		end

		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

[files.f]
rtl/wlg_pkg.sv
rtl/wlg_idx_div.sv
rtl/window_level_gray_table.sv
test/wlg_checker.sv
test/testbench.sv
